FILE: design/gcrl_pkg.sv
// Shared types, constants and the arctangent table of the great-circle route length unit.
// Used by gcrl_front, gcrl_back and the top level; depends on nothing else.
package gcrl_pkg;

  typedef struct packed {
    logic signed [29:0] latitude;
    logic signed [30:0] longitude;
    logic               last_stop;
    logic               round_trip;
  } item_t;

  typedef struct packed {
    logic [39:0] path_len;
    logic        length_saturated;
  } result_t;

  // Handshake between the front queue and the back engine.
  typedef struct packed {
    logic  valid;
    item_t item;
  } front_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_LOAD,
    ST_MOD,
    ST_FOLD,
    ST_ZMUL,
    ST_RINIT,
    ST_ROT,
    ST_COS,
    ST_MUL_C,
    ST_MUL_H,
    ST_AVAL,
    ST_SQRT,
    ST_VEC,
    ST_LEG_MUL,
    ST_ACC
  } back_state_e;

  localparam logic signed [33:0] Q30_ONE        = 34'sd1073741824;
  localparam logic signed [33:0] CORDIC_GAIN    = 34'sd652032874;
  localparam logic signed [32:0] DEG_TO_RAD_Q32 = 33'sd74961321;
  localparam logic signed [32:0] EARTH_DIAM_M   = 33'sd12742000;
  localparam logic [47:0]        SUM_MAX        = 48'hFFFF_FFFF_FFFF;
  localparam logic [39:0]        LENGTH_MAX     = 40'hFF_FFFF_FFFF;
  localparam logic [63:0]        SQRT_TOP_BIT   = 64'h4000_0000_0000_0000;

  localparam logic [29:0] ATAN_HEAD [11] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
    30'd1048575
  };

  // atan(2^-i) in Q30, truncated; exact powers of two for i = 11 to 30, zero beyond.
  function automatic logic signed [33:0] atan_q30(input logic [5:0] i);
    logic signed [33:0] r;
    if (i < 6'd11) begin
      r = 34'(ATAN_HEAD[i[3:0]]);
    end else if (i <= 6'd30) begin
      r = 34'sd1 <<< (6'd30 - i);
    end else begin
      r = 34'sd0;
    end
    return r;
  endfunction

endpackage

FILE: design/gcrl_front.sv
// Front part: accepts stops from the input stream and holds them in a two-entry queue.
// Depends on gcrl_pkg for the item type.
module gcrl_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  gcrl_pkg::item_t      in_item_i,
  output gcrl_pkg::front_req_t req_o,
  input  logic                 req_ready_i
);

  gcrl_pkg::item_t mem_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      count_q, count_d;
  logic            push, pop;

  assign in_ready_o = (count_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = req_ready_i && (count_q != 2'd0);

  assign req_o.valid = (count_q != 2'd0);
  assign req_o.item  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

FILE: design/gcrl_back.sv
// Back part: sequencer with a shared CORDIC unit, square-root unit and multiplier that
// computes each leg, keeps the running sum and drives the result register. Uses gcrl_pkg.
module gcrl_back #(
  parameter int CORDIC_STEPS        = 24,
  parameter int ANGLE_FRACTION_BITS = 22
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  gcrl_pkg::front_req_t req_i,
  output logic                 req_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output gcrl_pkg::result_t    out_o
);

  localparam int IT_W = $clog2(CORDIC_STEPS);
  localparam logic [33:0] FULL    = 34'(360) << ANGLE_FRACTION_BITS;
  localparam logic [33:0] HALF    = 34'(180) << ANGLE_FRACTION_BITS;
  localparam logic [33:0] QUARTER = 34'(90) << ANGLE_FRACTION_BITS;
  localparam int C_BITS = $clog2(360 << ANGLE_FRACTION_BITS);
  localparam int K_MAX  = 32 - C_BITS;
  localparam int K_W    = $clog2(K_MAX + 1);
  localparam logic [IT_W-1:0] IT_LAST = IT_W'(CORDIC_STEPS - 1);

  gcrl_pkg::back_state_e state_q, state_d;

  gcrl_pkg::item_t    item_q;
  logic signed [31:0] prev_lat_q, prev_lon_q;
  logic               have_prev_q;
  logic [47:0]        sum_q;
  logic               ovf_q;

  logic [1:0]         cos_idx_q;
  logic signed [31:0] cos_q [4];
  logic [33:0]        r_q, div_q;
  logic               dneg_q;
  logic [K_W-1:0]     kcnt_q;
  logic [31:0]        m_q;
  logic               negc_q;

  logic signed [33:0] x_q, y_q, z_q;
  logic [IT_W-1:0]    it_q;
  logic [30:0]        a_q;
  logic [63:0]        sq_v_q, sq_res_q, sq_bit_q;
  logic [4:0]         sq_cnt_q;
  logic               sq_pass_q;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_q;

  logic               out_valid_q;
  gcrl_pkg::result_t  out_q;

  // Operand of the current cosine.
  logic signed [32:0] d_op;
  logic [33:0]        d_mag;
  always_comb begin
    case (cos_idx_q)
      2'd0:    d_op = 33'(item_q.latitude) - 33'(prev_lat_q);
      2'd1:    d_op = 33'(item_q.longitude) - 33'(prev_lon_q);
      2'd2:    d_op = 33'(prev_lat_q);
      default: d_op = 33'(item_q.latitude);
    endcase
    d_mag = d_op[32] ? 34'(-34'(d_op)) : 34'(d_op);
  end

  // Folding of the reduced angle to [0, 180] degrees.
  logic [33:0] m0, m1;
  always_comb begin
    m0 = (dneg_q && (r_q != 34'd0)) ? FULL - r_q : r_q;
    m1 = (m0 >= HALF) ? FULL - m0 : m0;
  end

  // One CORDIC iteration, shared by rotation (cosine) and vectoring (arcsine).
  logic               sigma;
  logic signed [33:0] dx, dy, at;
  always_comb begin
    dx    = y_q >>> it_q;
    dy    = x_q >>> it_q;
    at    = gcrl_pkg::atan_q30(6'(it_q));
    sigma = (state_q == gcrl_pkg::ST_ROT) ? !z_q[33] : !(y_q > 34'sd0);
  end

  // One square-root step.
  logic [63:0] sq_trial, sq_res_n;
  logic        sq_take;
  always_comb begin
    sq_trial = sq_res_q + sq_bit_q;
    sq_take  = (sq_v_q >= sq_trial);
    sq_res_n = sq_take ? (sq_res_q >> 1) + sq_bit_q : (sq_res_q >> 1);
  end

  // Haversine terms.
  logic signed [33:0] h1, h2, a_sum, cos_x;
  always_comb begin
    h1    = (gcrl_pkg::Q30_ONE - 34'(cos_q[0])) >>> 1;
    h2    = (gcrl_pkg::Q30_ONE - 34'(cos_q[1])) >>> 1;
    a_sum = h1 + 34'(prod_q >>> 30);
    if (x_q < 34'sd0) begin
      cos_x = 34'sd0;
    end else if (x_q > gcrl_pkg::Q30_ONE) begin
      cos_x = gcrl_pkg::Q30_ONE;
    end else begin
      cos_x = x_q;
    end
  end

  logic [33:0] leg;
  logic [48:0] sum_ext, len_tot;
  logic [47:0] sum_fin;
  logic        ovf_fin, len_sat;
  logic        out_free, out_set;
  assign leg      = 34'((prod_q + 66'sd2097152) >>> 22);
  assign sum_ext  = {1'b0, sum_q} + 49'(leg);
  assign out_free = !out_valid_q || out_ready_i;
  assign out_set  = (state_q == gcrl_pkg::ST_ACC) && item_q.last_stop && out_free;

  // Sum with the pending leg folded in, and the length that it gives.
  always_comb begin
    sum_fin = sum_q;
    ovf_fin = ovf_q;
    if (have_prev_q) begin
      if (sum_ext[48]) begin
        sum_fin = gcrl_pkg::SUM_MAX;
        ovf_fin = 1'b1;
      end else begin
        sum_fin = sum_ext[47:0];
      end
    end
    len_tot = item_q.round_trip ? {1'b0, sum_fin} : {sum_fin, 1'b0};
    len_sat = ovf_fin || (len_tot[48:40] != 9'd0);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      gcrl_pkg::ST_IDLE:    if (req_i.valid) state_d = gcrl_pkg::ST_START;
      gcrl_pkg::ST_START:   state_d = have_prev_q ? gcrl_pkg::ST_LOAD : gcrl_pkg::ST_ACC;
      gcrl_pkg::ST_LOAD:    state_d = gcrl_pkg::ST_MOD;
      gcrl_pkg::ST_MOD:     if (kcnt_q == '0) state_d = gcrl_pkg::ST_FOLD;
      gcrl_pkg::ST_FOLD:    state_d = gcrl_pkg::ST_ZMUL;
      gcrl_pkg::ST_ZMUL:    state_d = gcrl_pkg::ST_RINIT;
      gcrl_pkg::ST_RINIT:   state_d = gcrl_pkg::ST_ROT;
      gcrl_pkg::ST_ROT:     if (it_q == IT_LAST) state_d = gcrl_pkg::ST_COS;
      gcrl_pkg::ST_COS:     state_d = (cos_idx_q == 2'd3) ? gcrl_pkg::ST_MUL_C
                                                          : gcrl_pkg::ST_LOAD;
      gcrl_pkg::ST_MUL_C:   state_d = gcrl_pkg::ST_MUL_H;
      gcrl_pkg::ST_MUL_H:   state_d = gcrl_pkg::ST_AVAL;
      gcrl_pkg::ST_AVAL:    state_d = gcrl_pkg::ST_SQRT;
      gcrl_pkg::ST_SQRT:    if (sq_cnt_q == 5'd31 && sq_pass_q) state_d = gcrl_pkg::ST_VEC;
      gcrl_pkg::ST_VEC:     if (it_q == IT_LAST) state_d = gcrl_pkg::ST_LEG_MUL;
      gcrl_pkg::ST_LEG_MUL: state_d = gcrl_pkg::ST_ACC;
      gcrl_pkg::ST_ACC:     if (!item_q.last_stop || out_free) state_d = gcrl_pkg::ST_IDLE;
      default:              state_d = gcrl_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: queue handshake and multiplier operands.
  always_comb begin
    req_ready_o = (state_q == gcrl_pkg::ST_IDLE);
    mul_a       = '0;
    mul_b       = '0;
    case (state_q)
      gcrl_pkg::ST_ZMUL: begin
        mul_a = 33'({1'b0, m_q});
        mul_b = gcrl_pkg::DEG_TO_RAD_Q32;
      end
      gcrl_pkg::ST_MUL_C: begin
        mul_a = 33'(cos_q[2]);
        mul_b = 33'(cos_q[3]);
      end
      gcrl_pkg::ST_MUL_H: begin
        mul_a = 33'(prod_q >>> 30);
        mul_b = 33'(h2);
      end
      gcrl_pkg::ST_LEG_MUL: begin
        mul_a = z_q[33] ? 33'sd0 : 33'(z_q);
        mul_b = gcrl_pkg::EARTH_DIAM_M;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (state_q)
      gcrl_pkg::ST_IDLE: begin
        item_q    <= req_i.item;
        cos_idx_q <= 2'd0;
      end
      gcrl_pkg::ST_LOAD: begin
        r_q    <= d_mag;
        dneg_q <= d_op[32];
        div_q  <= FULL << K_MAX;
        kcnt_q <= K_W'(K_MAX);
      end
      gcrl_pkg::ST_MOD: begin
        if (r_q >= div_q) r_q <= r_q - div_q;
        div_q  <= div_q >> 1;
        kcnt_q <= kcnt_q - 1'b1;
      end
      gcrl_pkg::ST_FOLD: begin
        if (m1 > QUARTER) begin
          m_q    <= 32'(HALF - m1);
          negc_q <= 1'b1;
        end else begin
          m_q    <= 32'(m1);
          negc_q <= 1'b0;
        end
      end
      gcrl_pkg::ST_RINIT: begin
        x_q  <= gcrl_pkg::CORDIC_GAIN;
        y_q  <= '0;
        z_q  <= $signed(prod_q[ANGLE_FRACTION_BITS+2 +: 34]);
        it_q <= '0;
      end
      gcrl_pkg::ST_ROT, gcrl_pkg::ST_VEC: begin
        if (sigma) begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          z_q <= z_q - at;
        end else begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          z_q <= z_q + at;
        end
        it_q <= it_q + 1'b1;
      end
      gcrl_pkg::ST_COS: begin
        cos_q[cos_idx_q] <= negc_q ? 32'(-cos_x) : 32'(cos_x);
        cos_idx_q        <= cos_idx_q + 2'd1;
      end
      gcrl_pkg::ST_AVAL: begin
        if (a_sum < 34'sd0) begin
          a_q <= '0;
        end else if (a_sum > gcrl_pkg::Q30_ONE) begin
          a_q <= 31'(gcrl_pkg::Q30_ONE);
        end else begin
          a_q <= 31'(a_sum);
        end
        if (a_sum < 34'sd0) begin
          sq_v_q <= '0;
        end else if (a_sum > gcrl_pkg::Q30_ONE) begin
          sq_v_q <= 64'(gcrl_pkg::Q30_ONE) << 30;
        end else begin
          sq_v_q <= 64'(a_sum) << 30;
        end
        sq_res_q  <= '0;
        sq_bit_q  <= gcrl_pkg::SQRT_TOP_BIT;
        sq_cnt_q  <= '0;
        sq_pass_q <= 1'b0;
      end
      gcrl_pkg::ST_SQRT: begin
        if (sq_cnt_q == 5'd31) begin
          // The first root gives the sine term, the second the cosine term.
          if (!sq_pass_q) begin
            y_q       <= 34'(sq_res_n);
            sq_v_q    <= (64'(gcrl_pkg::Q30_ONE) - 64'(a_q)) << 30;
            sq_res_q  <= '0;
            sq_bit_q  <= gcrl_pkg::SQRT_TOP_BIT;
            sq_cnt_q  <= '0;
            sq_pass_q <= 1'b1;
          end else begin
            x_q  <= 34'(sq_res_n);
            z_q  <= '0;
            it_q <= '0;
          end
        end else begin
          if (sq_take) sq_v_q <= sq_v_q - sq_trial;
          sq_res_q <= sq_res_n;
          sq_bit_q <= sq_bit_q >> 2;
          sq_cnt_q <= sq_cnt_q + 5'd1;
        end
      end
      default: begin
        it_q <= it_q;
      end
    endcase
  end

  // Route state, kept apart from the payload registers because reset clears it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gcrl_pkg::ST_IDLE;
      prev_lat_q  <= '0;
      prev_lon_q  <= '0;
      have_prev_q <= 1'b0;
      sum_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q <= state_d;
      if (out_set) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == gcrl_pkg::ST_ACC) begin
        if (!item_q.last_stop) begin
          sum_q       <= sum_fin;
          ovf_q       <= ovf_fin;
          prev_lat_q  <= 32'(item_q.latitude);
          prev_lon_q  <= 32'(item_q.longitude);
          have_prev_q <= 1'b1;
        end else if (have_prev_q && (state_d == gcrl_pkg::ST_ACC)) begin
          // Fold the last leg in while the result register is still busy.
          sum_q       <= sum_fin;
          ovf_q       <= ovf_fin;
          have_prev_q <= 1'b0;
        end else if (out_free) begin
          out_q.length_saturated <= len_sat;
          out_q.path_len         <= len_sat ? gcrl_pkg::LENGTH_MAX : len_tot[39:0];
          prev_lat_q  <= '0;
          prev_lon_q  <= '0;
          have_prev_q <= 1'b0;
          sum_q       <= '0;
          ovf_q       <= 1'b0;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

FILE: design/great_circle_route_length_unit.sv
// Channel   Dir  Payload (tdata low bits first)                      Marks
// s_axis    in   latitude[29:0], longitude[60:30], zeros to 64 bits   tlast last_stop,
//                                                                      tuser round_trip
// m_axis    out  path_len[39:0]                                        tuser length_saturated
//
// A stop with a previous stop runs the modulo-360 reduction and the one shared CORDIC unit
// for each of four cosines, the 32-step square-root unit twice and the CORDIC unit once more
// for one arcsine; a first stop skips all of these and goes straight to the accumulation.
// Reset is asynchronous and active low and clears the route state; no clearing pass.
// A two-stop input queue and the result register let either side stall on its own.
// Top level; instantiates gcrl_front and gcrl_back and uses gcrl_pkg.
module great_circle_route_length_unit #(
  parameter int CORDIC_STEPS        = 24,
  parameter int ANGLE_FRACTION_BITS = 22
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // latitude[29:0], longitude[60:30], zeros
  input  logic        s_axis_tlast,  // last_stop
  input  logic        s_axis_tuser,  // round_trip
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // path_len[39:0]
  output logic        m_axis_tuser   // length_saturated
);

  gcrl_pkg::item_t      in_item;
  gcrl_pkg::front_req_t req;
  logic                 req_ready;
  gcrl_pkg::result_t    result;

  assign in_item.latitude   = $signed(s_axis_tdata[29:0]);
  assign in_item.longitude  = $signed(s_axis_tdata[60:30]);
  assign in_item.last_stop  = s_axis_tlast;
  assign in_item.round_trip = s_axis_tuser;

  gcrl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (in_item),
    .req_o       (req),
    .req_ready_i (req_ready)
  );

  gcrl_back #(
    .CORDIC_STEPS        (CORDIC_STEPS),
    .ANGLE_FRACTION_BITS (ANGLE_FRACTION_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .req_ready_o (req_ready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (result)
  );

  assign m_axis_tdata = result.path_len;
  assign m_axis_tuser = result.length_saturated;

endmodule

FILE: design/gcrl_checker.sv
// Port-level checks of the great-circle route length unit and their bind.
// Watches only the top-level ports.
module gcrl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // A result waiting on the consumer stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // A clamped length always reads full scale.
  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 40'hFF_FFFF_FFFF)
    else $error("saturated length is not full scale");

  // A result only leaves once it was taken.
  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(m_axis_tvalid) |-> $past(m_axis_tready))
    else $error("result dropped without transaction");

endmodule

bind great_circle_route_length_unit gcrl_checker u_gcrl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
